// ===== rtl/core/calendar_day_number_convert_macros.svh =====
// Assertion macros for the calendar day number converter.
`ifndef CALENDAR_DAY_NUMBER_CONVERT_MACROS_SVH
`define CALENDAR_DAY_NUMBER_CONVERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define CDNC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define CDNC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CDNC_ASSERT_ALWAYS(lbl, prop, msg)
`define CDNC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/cdnc_pkg.sv =====
// Shared types, constants and tables for the calendar day number converter.
package cdnc_pkg;

    localparam int NSTAGE = 6;

    typedef enum logic [0:0] {
        CFG_SKIP_WEEKEND    = 1'b0,
        CFG_WEEKEND_FORWARD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic skip_weekend;
        logic weekend_forward;
    } cfg_t;

    typedef struct packed {
        logic [NSTAGE-1:0] ld;        // load enable of each pipeline stage
        logic              mode_last; // mode of the item in the last stage
    } pipe_ctl_t;

    // Days before the start of each month, counted from March
    function automatic logic [8:0] month_offset(input logic [3:0] mon);
        logic [8:0] r;
        case (mon)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/cdnc_ctrl.sv =====
// Pipeline control: valid bits, mode bits and per-stage load enables.
module cdnc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_mode,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output cdnc_pkg::pipe_ctl_t  ctl
);
    import cdnc_pkg::*;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] mode_reg;
    logic [NSTAGE-1:0] mode_next;
    logic [NSTAGE-1:0] rdy;

    // A stage may load when it is empty or its content moves on
    always_comb
    begin
        rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        mode_next  = mode_reg;
        if (rdy[0])
        begin
            valid_next[0] = s_tvalid;
            mode_next[0]  = s_mode;
        end
        for (int k = 1; k < NSTAGE; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = valid_reg[k-1];
                mode_next[k]  = mode_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mode_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            mode_reg  <= mode_next;
        end
    end

    assign s_tready      = rdy[0];
    assign m_tvalid      = valid_reg[NSTAGE-1];
    assign ctl.ld        = rdy;
    assign ctl.mode_last = mode_reg[NSTAGE-1];

endmodule

// ===== rtl/core/cdnc_fwd.sv =====
// Forward path: day, month and year to a day number, six register stages.
module cdnc_fwd (
    input  logic                 clk,
    input  cdnc_pkg::pipe_ctl_t  ctl,
    input  cdnc_pkg::cfg_t       cfg,
    input  logic [4:0]           day,
    input  logic [3:0]           month,
    input  logic [13:0]          year,
    output logic                 fwd_ok,
    output logic signed [22:0]   fwd_day_number
);
    import cdnc_pkg::*;

    localparam logic [12:0] RECIP_100  = 13'd5243;   // 2^19 / 100, rounded up
    localparam logic [17:0] DAYS_4CEN  = 18'd146097;
    localparam logic [10:0] DAYS_4YR   = 11'd1461;
    localparam logic [23:0] EPOCH_OFS  = 24'd693902; // epoch minus base

    // stage 1
    logic        f1_ok_reg,  f1_ok_next;
    logic [4:0]  f1_d_reg,   f1_d_next;
    logic [3:0]  f1_m_reg;
    logic [13:0] f1_y_reg;
    logic [26:0] f1_q_reg,   f1_q_next;
    // stage 2
    logic        f2_ok_reg;
    logic [4:0]  f2_d_reg;
    logic [6:0]  f2_cen_reg, f2_cen_next;
    logic [6:0]  f2_yr_reg,  f2_yr_next;
    logic [3:0]  f2_mon_reg, f2_mon_next;
    // stage 3
    logic        f3_ok_reg;
    logic [4:0]  f3_d_reg;
    logic [24:0] f3_a_reg,   f3_a_next;
    logic [17:0] f3_b_reg,   f3_b_next;
    logic [8:0]  f3_mt_reg,  f3_mt_next;
    // stage 4
    logic        f4_ok_reg;
    logic [22:0] f4_date_reg, f4_date_next;
    // stage 5
    logic        f5_ok_reg;
    logic [22:0] f5_date_reg;
    logic [2:0]  f5_wd_reg,  f5_wd_next;
    // stage 6
    logic        f6_ok_reg;
    logic [22:0] f6_dn_reg,  f6_dn_next;

    logic [6:0]  cen0, cen1, yr0;
    logic [13:0] hund, rem;
    logic [23:0] sum;

    // stage 1: range check, leap day clamp, century estimate
    always_comb
    begin
        f1_ok_next = !(day == 5'd0 || month == 4'd0 || year == 14'd0 ||
                       month > 4'd12 || year > 14'd9999);
        f1_d_next  = (month == 4'd2 && day == 5'd29) ? 5'd28 : day;
        f1_q_next  = 27'(year) * 27'(RECIP_100);
    end

    // stage 2: split year, shift the year to start in March
    always_comb
    begin
        cen0 = f1_q_reg[25:19];
        hund = 14'(cen0) * 14'd100;
        rem  = f1_y_reg - hund;
        yr0  = rem[6:0];
        cen1 = (cen0 == 7'd0) ? 7'd20 : cen0;
        if (f1_m_reg > 4'd2)
        begin
            f2_mon_next = f1_m_reg - 4'd3;
            f2_yr_next  = yr0;
            f2_cen_next = cen1;
        end
        else
        begin
            f2_mon_next = f1_m_reg + 4'd9;
            f2_yr_next  = (yr0 != 7'd0) ? yr0 - 7'd1 : 7'd99;
            f2_cen_next = (yr0 != 7'd0) ? cen1 : cen1 - 7'd1;
        end
    end

    // stage 3: century, year and month terms
    always_comb
    begin
        f3_a_next  = 25'(f2_cen_reg) * 25'(DAYS_4CEN);
        f3_b_next  = 18'(f2_yr_reg) * 18'(DAYS_4YR);
        f3_mt_next = month_offset(f2_mon_reg);
    end

    // stage 4: sum of terms less the epoch
    always_comb
    begin
        sum = 24'(f3_a_reg[24:2]) + 24'(f3_b_reg[17:2]) + 24'(f3_mt_reg) +
              24'(f3_d_reg) - EPOCH_OFS;
        f4_date_next = sum[22:0];
    end

    // stage 5: weekday by folding octal digits, since 8 is 1 modulo 7
    always_comb
    begin
        logic [23:0] v;
        logic [5:0]  s;
        logic [3:0]  f;
        logic [2:0]  g;
        v = {2'b00, f4_date_reg[21:0]};
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + 6'(v[3*i +: 3]);
        end
        f = 4'(s[5:3]) + 4'(s[2:0]);
        g = f[2:0] + 3'(f[3]);
        f5_wd_next = (g == 3'd7) ? 3'd0 : g;
    end

    // stage 6: weekend move and clearing of invalid results
    always_comb
    begin
        logic [22:0] delta;
        delta = '0;
        if (cfg.skip_weekend && !f5_date_reg[22])
        begin
            case (f5_wd_reg)
                3'd6:    delta = cfg.weekend_forward ? 23'd1 : -23'sd2;
                3'd5:    delta = cfg.weekend_forward ? 23'd2 : -23'sd1;
                default: delta = '0;
            endcase
        end
        f6_dn_next = f5_ok_reg ? f5_date_reg + delta : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[0])
        begin
            f1_ok_reg <= f1_ok_next;
            f1_d_reg  <= f1_d_next;
            f1_m_reg  <= month;
            f1_y_reg  <= year;
            f1_q_reg  <= f1_q_next;
        end
        if (ctl.ld[1])
        begin
            f2_ok_reg  <= f1_ok_reg;
            f2_d_reg   <= f1_d_reg;
            f2_cen_reg <= f2_cen_next;
            f2_yr_reg  <= f2_yr_next;
            f2_mon_reg <= f2_mon_next;
        end
        if (ctl.ld[2])
        begin
            f3_ok_reg <= f2_ok_reg;
            f3_d_reg  <= f2_d_reg;
            f3_a_reg  <= f3_a_next;
            f3_b_reg  <= f3_b_next;
            f3_mt_reg <= f3_mt_next;
        end
        if (ctl.ld[3])
        begin
            f4_ok_reg   <= f3_ok_reg;
            f4_date_reg <= f4_date_next;
        end
        if (ctl.ld[4])
        begin
            f5_ok_reg   <= f4_ok_reg;
            f5_date_reg <= f4_date_reg;
            f5_wd_reg   <= f5_wd_next;
        end
        if (ctl.ld[5])
        begin
            f6_ok_reg <= f5_ok_reg;
            f6_dn_reg <= f6_dn_next;
        end
    end

    assign fwd_ok         = f6_ok_reg;
    assign fwd_day_number = f6_dn_reg;

endmodule

// ===== rtl/core/cdnc_inv.sv =====
// Inverse path: day number to year, month and day, six register stages.
module cdnc_inv (
    input  logic                 clk,
    input  cdnc_pkg::pipe_ctl_t  ctl,
    input  logic [16:0]          day_count,
    output logic                 inv_ok,
    output logic [13:0]          inv_year,
    output logic [3:0]           inv_month,
    output logic [4:0]           inv_day
);
    import cdnc_pkg::*;

    localparam logic [16:0] MAX_COUNT  = 17'd73000;
    localparam logic [21:0] X_OFS      = 22'd2775607;  // 4 * (epoch - base) - 1
    localparam logic [21:0] DAYS_4CEN  = 22'd146097;
    localparam logic [21:0] CEN19_LIM  = 22'(19 * 146097);
    localparam logic [21:0] CEN20_LIM  = 22'(20 * 146097);
    localparam logic [17:0] RECIP_1461 = 18'd183734;   // 2^28 / 1461, rounded down
    localparam logic [11:0] DAYS_4YR   = 12'd1461;
    localparam logic [12:0] RECIP_153  = 13'd6854;     // 2^20 / 153, rounded up

    // stage 1
    logic        i1_ok_reg, i1_ok_next;
    logic [21:0] i1_x_reg,  i1_x_next;
    // stage 2
    logic        i2_ok_reg;
    logic [4:0]  i2_c_reg,  i2_c_next;
    logic [15:0] i2_dd_reg, i2_dd_next;
    // stage 3
    logic        i3_ok_reg;
    logic [4:0]  i3_c_reg;
    logic [17:0] i3_xy_reg, i3_xy_next;
    logic [35:0] i3_p_reg,  i3_p_next;
    // stage 4
    logic        i4_ok_reg;
    logic [4:0]  i4_c_reg;
    logic [6:0]  i4_y_reg,  i4_y_next;
    logic [10:0] i4_r_reg,  i4_r_next;
    // stage 5
    logic        i5_ok_reg;
    logic [4:0]  i5_c_reg;
    logic [6:0]  i5_y_reg;
    logic [10:0] i5_xm_reg, i5_xm_next;
    logic [23:0] i5_p_reg,  i5_p_next;
    // stage 6
    logic        i6_ok_reg;
    logic [13:0] i6_year_reg,  i6_year_next;
    logic [3:0]  i6_month_reg, i6_month_next;
    logic [4:0]  i6_day_reg,   i6_day_next;

    logic [21:0] r2;
    logic [7:0]  q0;
    logic [17:0] r4;
    logic [8:0]  dd3;

    // stage 1: shift to the March-based count, scaled by four
    always_comb
    begin
        i1_ok_next = (day_count <= MAX_COUNT);
        i1_x_next  = 22'({day_count, 2'b00}) + X_OFS;
    end

    // stage 2: century by comparison, only three are reachable
    always_comb
    begin
        if (i1_x_reg >= CEN20_LIM)
        begin
            i2_c_next = 5'd20;
        end
        else if (i1_x_reg >= CEN19_LIM)
        begin
            i2_c_next = 5'd19;
        end
        else
        begin
            i2_c_next = 5'd18;
        end
        r2 = i1_x_reg - 22'(i2_c_next) * DAYS_4CEN;
        i2_dd_next = r2[17:2];
    end

    // stage 3: year within the century by reciprocal
    always_comb
    begin
        i3_xy_next = {i2_dd_reg, 2'b11};
        i3_p_next  = 36'(i3_xy_next) * 36'(RECIP_1461);
    end

    // stage 4: correct the quotient estimate by at most one
    always_comb
    begin
        q0 = i3_p_reg[35:28];
        r4 = i3_xy_reg - 18'(q0) * 18'(DAYS_4YR);
        if (r4 >= 18'(DAYS_4YR))
        begin
            i4_y_next = 7'(q0 + 8'd1);
            i4_r_next = 11'(r4 - 18'(DAYS_4YR));
        end
        else
        begin
            i4_y_next = q0[6:0];
            i4_r_next = r4[10:0];
        end
    end

    // stage 5: day of year, month estimate
    always_comb
    begin
        dd3        = 9'(i4_r_reg[10:2]) + 9'd1;
        i5_xm_next = 11'(dd3) * 11'd5 - 11'd3;
        i5_p_next  = 24'(i5_xm_next) * 24'(RECIP_153);
    end

    // stage 6: day of month, move back to a January-based year
    always_comb
    begin
        logic [3:0]  m;
        logic [7:0]  dr;
        logic [15:0] dq;
        logic [6:0]  y;
        logic [4:0]  c;
        m  = i5_p_reg[23:20];
        dr = 8'(i5_xm_reg - 11'(m) * 11'd153);
        dq = 16'(dr + 8'd5) * 16'd205;
        y  = i5_y_reg;
        c  = i5_c_reg;
        if (m < 4'd10)
        begin
            m = m + 4'd3;
        end
        else
        begin
            m = m - 4'd9;
            if (y == 7'd99)
            begin
                y = 7'd0;
                c = c + 5'd1;
            end
            else
            begin
                y = y + 7'd1;
            end
        end
        if (i5_ok_reg)
        begin
            i6_year_next  = 14'(c) * 14'd100 + 14'(y);
            i6_month_next = m;
            i6_day_next   = dq[14:10];
        end
        else
        begin
            i6_year_next  = '0;
            i6_month_next = '0;
            i6_day_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[0])
        begin
            i1_ok_reg <= i1_ok_next;
            i1_x_reg  <= i1_x_next;
        end
        if (ctl.ld[1])
        begin
            i2_ok_reg <= i1_ok_reg;
            i2_c_reg  <= i2_c_next;
            i2_dd_reg <= i2_dd_next;
        end
        if (ctl.ld[2])
        begin
            i3_ok_reg <= i2_ok_reg;
            i3_c_reg  <= i2_c_reg;
            i3_xy_reg <= i3_xy_next;
            i3_p_reg  <= i3_p_next;
        end
        if (ctl.ld[3])
        begin
            i4_ok_reg <= i3_ok_reg;
            i4_c_reg  <= i3_c_reg;
            i4_y_reg  <= i4_y_next;
            i4_r_reg  <= i4_r_next;
        end
        if (ctl.ld[4])
        begin
            i5_ok_reg <= i4_ok_reg;
            i5_c_reg  <= i4_c_reg;
            i5_y_reg  <= i4_y_reg;
            i5_xm_reg <= i5_xm_next;
            i5_p_reg  <= i5_p_next;
        end
        if (ctl.ld[5])
        begin
            i6_ok_reg    <= i5_ok_reg;
            i6_year_reg  <= i6_year_next;
            i6_month_reg <= i6_month_next;
            i6_day_reg   <= i6_day_next;
        end
    end

    assign inv_ok    = i6_ok_reg;
    assign inv_year  = i6_year_reg;
    assign inv_month = i6_month_reg;
    assign inv_day   = i6_day_reg;

endmodule

// ===== rtl/core/calendar_day_number_convert.sv =====
// Top level of the calendar day number converter.
//
// Converts a date to a day number counted from 1900-01-01 (tuser 0), or a
// day number back to a date (tuser 1), by the Julian day method. Every
// input transaction gives exactly one output transaction, in order. The
// block takes one transaction per clock cycle while the output is not
// stalled; each result passes through the six-stage pipeline, whose valid
// bits both conversion paths share. Each stage has its own valid bit and
// loads whenever it is empty or its content moves on, so a stalled output
// only holds back stages that are already full and bubbles close up. The
// weekend settings are sampled in the last stage; write them only while no
// transaction is in flight. There is no memory and no clearing after reset.

`include "calendar_day_number_convert_macros.svh"

module calendar_day_number_convert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // day[4:0], month[8:5], year[22:9], day_count[39:23]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // day_number[22:0], out_year[36:23], out_month[40:37],
                                   // out_day[45:41], zero[47:46]
    output logic [0:0]  m_tuser,   // valid_res[0]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [0:0]  cfg_data
);
    import cdnc_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    pipe_ctl_t   ctl;

    logic               fwd_ok;
    logic signed [22:0] fwd_day_number;
    logic               inv_ok;
    logic [13:0]        inv_year;
    logic [3:0]         inv_month;
    logic [4:0]         inv_day;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SKIP_WEEKEND:    cfg_next.skip_weekend    = cfg_data[0];
                CFG_WEEKEND_FORWARD: cfg_next.weekend_forward = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_weekend    <= 1'b1;
            cfg_reg.weekend_forward <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cdnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    cdnc_fwd u_fwd (
        .clk            (clk),
        .ctl            (ctl),
        .cfg            (cfg_reg),
        .day            (s_tdata[4:0]),
        .month          (s_tdata[8:5]),
        .year           (s_tdata[22:9]),
        .fwd_ok         (fwd_ok),
        .fwd_day_number (fwd_day_number)
    );

    cdnc_inv u_inv (
        .clk       (clk),
        .ctl       (ctl),
        .day_count (s_tdata[39:23]),
        .inv_ok    (inv_ok),
        .inv_year  (inv_year),
        .inv_month (inv_month),
        .inv_day   (inv_day)
    );

    // Zero the fields of the path that the item did not use
    always_comb
    begin
        if (ctl.mode_last)
        begin
            m_tuser[0] = inv_ok;
            m_tdata    = {2'b00, inv_day, inv_month, inv_year, 23'd0};
        end
        else
        begin
            m_tuser[0] = fwd_ok;
            m_tdata    = {2'b00, 5'd0, 4'd0, 14'd0, fwd_day_number};
        end
    end

    `CDNC_ASSERT_IMPL(a_invalid_is_zero, m_tvalid && !m_tuser[0], m_tdata == 48'd0, "invalid result carries data")
    `CDNC_ASSERT_IMPL(a_stall_only_when_full, !s_tready, m_tvalid, "input held off with no result pending")
    `CDNC_ASSERT_IMPL(a_inverse_date_sane, m_tvalid && m_tuser[0] && ctl.mode_last, inv_month >= 4'd1 && inv_month <= 4'd12 && inv_day >= 5'd1, "inverse date out of range")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the calendar day number converter.
`timescale 1ns / 1ps

module tb_top;
    import cdnc_pkg::*;

    localparam logic MODE_DATE_TO_NUM = 1'b0;
    localparam logic MODE_NUM_TO_DATE = 1'b1;

    localparam longint JDN_EPOCH  = 2415021;
    localparam longint JDN_BASE   = 1721119;
    localparam int     MAX_COUNT  = 365 * 200;
    localparam int     MAX_YEAR   = 9999;
    localparam int     MAX_REPORT = 10;

    typedef struct packed {
        logic        mode;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [16:0] day_count;
    } date_req_t;

    typedef struct packed {
        logic               valid_res;
        logic signed [22:0] day_number;
        logic [13:0]        out_year;
        logic [3:0]         out_month;
        logic [4:0]         out_day;
    } date_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [0:0]  cfg_data;

    // local copy of the weekend settings, as after reset
    bit skip_wkend_cfg = 1'b1;
    bit wkend_fwd_cfg  = 1'b1;

    date_res_t pending_results[$];
    int        errors      = 0;
    bit        steady_flow = 1'b0;

    calendar_day_number_convert uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic date_res_t convert_date(input date_req_t r);
        date_res_t o;
        longint    d, mon, yr, cen, num, wd;
        longint    t, c, rem, dd, y, m;
        o = '0;
        if (r.mode == MODE_DATE_TO_NUM)
        begin
            if (r.day != 0 && r.month != 0 && r.year != 0 && r.month <= 12
                && r.year <= MAX_YEAR)
            begin
                d = longint'(r.day);
                // 29 February always counts as the 28th
                if (r.month == 2 && r.day == 29)
                    d = 28;
                mon = longint'(r.month);
                yr  = longint'(r.year) % 100;
                cen = longint'(r.year) / 100;
                if (cen == 0)
                    cen = 20;
                if (mon > 2)
                    mon -= 3;
                else
                begin
                    mon += 9;
                    if (yr != 0)
                        yr--;
                    else
                    begin
                        yr = 99;
                        cen--;
                    end
                end
                num = (146097 * cen) / 4 + (1461 * yr) / 4 + (153 * mon + 2) / 5
                      + d + JDN_BASE - JDN_EPOCH;
                if (skip_wkend_cfg && num >= 0)
                begin
                    wd = num % 7;
                    if (wd == 6)
                        num += wkend_fwd_cfg ? 1 : -2;
                    else if (wd == 5)
                        num += wkend_fwd_cfg ? 2 : -1;
                end
                o.valid_res  = 1'b1;
                o.day_number = num[22:0];
            end
        end
        else if (r.day_count <= MAX_COUNT)
        begin
            t   = longint'(r.day_count) + JDN_EPOCH - JDN_BASE;
            c   = (4 * t - 1) / 146097;
            rem = 4 * t - 1 - 146097 * c;
            dd  = rem / 4;
            y   = (4 * dd + 3) / 1461;
            dd  = 4 * dd + 3 - 1461 * y;
            dd  = (dd + 4) / 4;
            m   = (5 * dd - 3) / 153;
            dd  = 5 * dd - 3 - 153 * m;
            dd  = (dd + 5) / 5;
            // March-based month back to January-based, carrying into the year
            if (m < 10)
                m += 3;
            else
            begin
                m -= 9;
                if (y == 99)
                begin
                    y = 0;
                    c++;
                end
                else
                    y++;
            end
            o.valid_res = 1'b1;
            o.out_year  = 14'(y + c * 100);
            o.out_month = 4'(m);
            o.out_day   = 5'(dd);
        end
        return o;
    endfunction

    function automatic date_req_t make_date(input int d, input int m, input int y);
        date_req_t r;
        r.mode      = MODE_DATE_TO_NUM;
        r.day       = 5'(d);
        r.month     = 4'(m);
        r.year      = 14'(y);
        r.day_count = 17'($urandom);
        return r;
    endfunction

    function automatic date_req_t make_count(input int n);
        date_req_t r;
        r.mode      = MODE_NUM_TO_DATE;
        r.day       = 5'($urandom);
        r.month     = 4'($urandom);
        r.year      = 14'($urandom);
        r.day_count = 17'(n);
        return r;
    endfunction

    function automatic date_req_t random_request();
        int d, m, y, n;
        if ($urandom_range(0, 9) < 6)
        begin
            d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 31);
            m = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0:       y = $urandom_range(1, 99);
                1, 2, 3,
                4:       y = $urandom_range(1900, 2100);
                5, 6,
                7:       y = $urandom_range(1, MAX_YEAR);
                8:       y = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(10000, 16383);
                default: y = $urandom_range(0, 16383);
            endcase
            return make_date(d, m, y);
        end
        case ($urandom_range(0, 19))
            0:       n = ($urandom_range(0, 1) == 0) ? 0 : MAX_COUNT;
            1, 2:    n = $urandom_range(MAX_COUNT + 1, 131071);
            default: n = $urandom_range(0, MAX_COUNT);
        endcase
        return make_count(n);
    endfunction

    // Present one request after a random gap, none in steady runs, and hold it until taken.
    task automatic send_request(input date_req_t r);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.day_count, r.year, r.month, r.day};
        s_tuser  <= r.mode;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(convert_date(r));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Write both weekend registers back to back once nothing is in flight.
    task automatic write_weekend_cfg(input bit skip, input bit fwd);
        drain_pipeline();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SKIP_WEEKEND;
        cfg_data  <= skip;
        @(posedge clk);
        cfg_index <= CFG_WEEKEND_FORWARD;
        cfg_data  <= fwd;
        @(posedge clk);
        cfg_we         <= 1'b0;
        skip_wkend_cfg = skip;
        wkend_fwd_cfg  = fwd;
    endtask

    task automatic test_date_to_number_edges();
        send_request(make_date(1, 1, 1900));
        send_request(make_date(6, 1, 1900));     // Saturday
        send_request(make_date(7, 1, 1900));     // Sunday
        send_request(make_date(31, 12, MAX_YEAR));
        send_request(make_date(1, 1, 1));        // short year
        send_request(make_date(31, 12, 99));
        send_request(make_date(1, 1, 100));      // century borrow in January
        send_request(make_date(1, 3, 1583));     // before the epoch, never moved
        send_request(make_date(29, 2, 2024));
        send_request(make_date(31, 2, 2023));    // runs into March
        send_request(make_date(31, 15, 16383));
        send_request(make_date(0, 6, 2000));
        send_request(make_date(15, 0, 2000));
        send_request(make_date(15, 6, 0));
        send_request(make_date(15, 13, 2000));
        send_request(make_date(15, 6, 10000));
    endtask

    task automatic test_number_to_date_edges();
        send_request(make_count(0));
        send_request(make_count(59));
        send_request(make_count(60));
        send_request(make_count(36524));
        send_request(make_count(MAX_COUNT));
        send_request(make_count(MAX_COUNT + 1));
        send_request(make_count(131071));
    endtask

    task automatic test_random_traffic(input bit skip, input bit fwd, input int count);
        write_weekend_cfg(skip, fwd);
        for (int i = 0; i < count; i++)
        begin
            // alternate runs of back-to-back traffic with gappy traffic
            if (i % 40 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            send_request(random_request());
        end
        steady_flow = 1'b0;
    endtask

    // Sink side: random stall before each result, none in steady runs.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        date_res_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.valid_res  = m_tuser[0];
            got.day_number = m_tdata[22:0];
            got.out_year   = m_tdata[36:23];
            got.out_month  = m_tdata[40:37];
            got.out_day    = m_tdata[45:41];
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORT)
                    $display("unexpected transaction: valid %0b number %0d date %0d-%0d-%0d",
                             got.valid_res, got.day_number, got.out_year, got.out_month,
                             got.out_day);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.valid_res !== want.valid_res || got.day_number !== want.day_number
                    || got.out_year !== want.out_year || got.out_month !== want.out_month
                    || got.out_day !== want.out_day)
                begin
                    errors++;
                    if (errors <= MAX_REPORT)
                        $display("mismatch: expected valid %0b number %0d date %0d-%0d-%0d, %s",
                                 want.valid_res, want.day_number, want.out_year,
                                 want.out_month, want.out_day,
                                 $sformatf("got valid %0b number %0d date %0d-%0d-%0d",
                                           got.valid_res, got.day_number, got.out_year,
                                           got.out_month, got.out_day));
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("calendar_day_number_convert regression: fail");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_SKIP_WEEKEND;
        cfg_data  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_date_to_number_edges();
        test_number_to_date_edges();
        test_random_traffic(1'b1, 1'b0, 190);
        test_random_traffic(1'b0, 1'b0, 185);
        test_random_traffic(1'b0, 1'b1, 185);
        test_random_traffic(1'b1, 1'b1, 190);

        drain_pipeline();
        repeat (12) @(posedge clk);
        if (errors == 0)
            $display("calendar_day_number_convert regression: pass");
        else
            $display("calendar_day_number_convert regression: fail");
        $finish;
    end

endmodule
